// ----- sv/fbrc_pkg.sv -----
`timescale 1ns / 1ps

package fbrc_pkg;

  // Field widths fixed by the item format
  localparam int PTR_W   = 64;
  localparam int SIZE_W  = 48;
  localparam int TOTAL_W = 52;
  localparam int FUNC_W  = 2;
  localparam int KIND_W  = 3;
  localparam int CFG_W   = 5;

  // Stream payload widths (zero padded to whole bytes)
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 168;

  // Operation selector on the input side
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_FIND   = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  // Result kind on the output side
  typedef enum logic [KIND_W-1:0] {
    K_STORED  = 3'd0,
    K_RELEASE = 3'd1,
    K_HIT     = 3'd2,
    K_MISS    = 3'd3,
    K_DONE    = 3'd4
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_WR,
    ST_FIND_CHK,
    ST_MISS,
    ST_CLR_CHK,
    ST_CLR_DONE
  } state_t;

  // One table row
  typedef struct packed {
    logic [PTR_W-1:0]  ptr;
    logic [SIZE_W-1:0] size;
  } slot_row_t;

endpackage

// ----- sv/free_block_recycle_cache_core.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   tuser: func; tdata: block_pointer, size_bytes
// m_*      out  m_tvalid/m_tready   tuser: kind; tdata: out_pointer, out_bytes,
//                                   total_held; tlast: last
// cfg_*    in   cfg_valid/cfg_ready cfg_data: entries_in_use
//
// Insert steps through accept, slot check and write; find scans the active
// slots and clear the whole table, and output stalls hold each. The table is
// one single-port-read memory scanned one slot per cycle unless an output
// stall holds it, with one shared 52-bit add/subtract unit for the running total.
// Reset clears the occupancy flags at once; no clearing pass is needed.
// A result waits in the output register while m_tready is low; the
// sequencer holds until that register is free.
module free_block_recycle_cache_core #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // slave stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [fbrc_pkg::IN_DATA_W-1:0]   s_tdata,   // [63:0] block_pointer, [111:64] size_bytes
  input  logic [fbrc_pkg::FUNC_W-1:0]      s_tuser,   // [1:0] func
  // master stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [fbrc_pkg::OUT_DATA_W-1:0]  m_tdata,   // [63:0] out_pointer, [111:64] out_bytes,
                                                      // [163:112] total_held, rest zero
  output logic [fbrc_pkg::KIND_W-1:0]      m_tuser,   // [2:0] kind
  output logic                             m_tlast,
  // configuration write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbrc_pkg::CFG_W-1:0]       cfg_data   // [4:0] entries_in_use
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [fbrc_pkg::CFG_W-1:0] CFG_RST =
    (DEPTH > 31) ? fbrc_pkg::CFG_W'(31) : fbrc_pkg::CFG_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam int PAD_W = fbrc_pkg::OUT_DATA_W - fbrc_pkg::PTR_W - fbrc_pkg::SIZE_W
                         - fbrc_pkg::TOTAL_W;

  fbrc_pkg::state_t state, state_next;

  // Request registers
  fbrc_pkg::func_t                 req_func;
  logic [fbrc_pkg::PTR_W-1:0]      req_ptr;
  logic [fbrc_pkg::SIZE_W-1:0]     req_size;

  // Table state
  fbrc_pkg::slot_row_t             mem [DEPTH];
  fbrc_pkg::slot_row_t             rd_row;
  logic [DEPTH-1:0]                valid;
  logic [IDX_W-1:0]                idx, idx_next;
  logic [IDX_W-1:0]                next_slot, next_slot_next;
  logic [fbrc_pkg::TOTAL_W-1:0]    held_total;
  logic [fbrc_pkg::CFG_W-1:0]      entries_in_use;

  // Output register
  logic                            out_valid;
  fbrc_pkg::kind_t                 out_kind;
  logic [fbrc_pkg::PTR_W-1:0]      out_ptr;
  logic [fbrc_pkg::SIZE_W-1:0]     out_bytes;
  logic [fbrc_pkg::TOTAL_W-1:0]    out_total;
  logic                            out_last;

  // Control from the sequencer
  logic                            out_free;
  logic                            emit;
  fbrc_pkg::kind_t                 emit_kind;
  logic [fbrc_pkg::PTR_W-1:0]      emit_ptr;
  logic [fbrc_pkg::SIZE_W-1:0]     emit_bytes;
  logic [fbrc_pkg::TOTAL_W-1:0]    emit_total;
  logic                            emit_last;
  logic                            held_we;
  logic                            held_clr;
  logic                            mem_we;
  logic                            valid_we;
  logic                            valid_val;
  logic                            ns_we;

  // Shared add/subtract unit
  logic                            add_sub;
  logic [fbrc_pkg::SIZE_W-1:0]     add_opnd;
  logic [fbrc_pkg::TOTAL_W-1:0]    add_ext;
  logic [fbrc_pkg::TOTAL_W-1:0]    add_sum;

  // Active slot count and derived compares
  logic [CNT_W-1:0]                act_cnt;
  logic [CNT_W-1:0]                idx_inc;
  logic [IDX_W-1:0]                ins_start;
  logic                            row_match;

  assign s_tready  = (state == fbrc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {{PAD_W{1'b0}}, out_total, out_bytes, out_ptr};

  // Effective slot count: zero means one, above DEPTH means DEPTH
  always_comb begin
    if (entries_in_use == '0) begin
      act_cnt = CNT_W'(1);
    end else if (int'(entries_in_use) > DEPTH) begin
      act_cnt = CNT_W'(DEPTH);
    end else begin
      act_cnt = CNT_W'(entries_in_use);
    end
  end

  assign idx_inc   = CNT_W'(idx) + CNT_W'(1);
  assign ins_start = (CNT_W'(next_slot) < act_cnt) ? next_slot : '0;
  assign row_match = valid[idx] && (rd_row.size == req_size);

  assign add_ext = fbrc_pkg::TOTAL_W'(add_opnd);
  assign add_sum = add_sub ? (held_total - add_ext) : (held_total + add_ext);

  // Sequencer: next state and control
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    next_slot_next = idx_inc < act_cnt ? idx_inc[IDX_W-1:0] : '0;
    emit           = 1'b0;
    emit_kind      = fbrc_pkg::K_STORED;
    emit_ptr       = '0;
    emit_bytes     = '0;
    emit_total     = held_total;
    emit_last      = 1'b0;
    held_we        = 1'b0;
    held_clr       = 1'b0;
    mem_we         = 1'b0;
    valid_we       = 1'b0;
    valid_val      = 1'b0;
    ns_we          = 1'b0;
    add_sub        = 1'b1;
    add_opnd       = rd_row.size;

    unique case (state)
      fbrc_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          unique case (fbrc_pkg::func_t'(s_tuser))
            fbrc_pkg::FN_INSERT: begin
              idx_next   = ins_start;
              state_next = fbrc_pkg::ST_INS_CHK;
            end
            fbrc_pkg::FN_FIND: begin
              idx_next   = '0;
              state_next = (s_tdata[fbrc_pkg::PTR_W +: fbrc_pkg::SIZE_W] == '0)
                           ? fbrc_pkg::ST_MISS : fbrc_pkg::ST_FIND_CHK;
            end
            fbrc_pkg::FN_CLEAR: begin
              idx_next   = '0;
              state_next = fbrc_pkg::ST_CLR_CHK;
            end
            default: begin
              state_next = fbrc_pkg::ST_IDLE;
            end
          endcase
        end
      end

      // evict the old block if the slot is occupied
      fbrc_pkg::ST_INS_CHK: begin
        if (!valid[idx]) begin
          state_next = fbrc_pkg::ST_INS_WR;
        end else if (out_free) begin
          emit       = 1'b1;
          emit_kind  = fbrc_pkg::K_RELEASE;
          emit_ptr   = rd_row.ptr;
          emit_bytes = rd_row.size;
          emit_total = add_sum;
          held_we    = 1'b1;
          state_next = fbrc_pkg::ST_INS_WR;
        end
      end

      // store the new block and advance the round-robin slot
      fbrc_pkg::ST_INS_WR: begin
        add_sub  = 1'b0;
        add_opnd = req_size;
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = fbrc_pkg::K_STORED;
          emit_total = add_sum;
          emit_last  = 1'b1;
          held_we    = 1'b1;
          mem_we     = 1'b1;
          valid_we   = 1'b1;
          valid_val  = (req_size != '0);
          ns_we      = 1'b1;
          state_next = fbrc_pkg::ST_IDLE;
        end
      end

      // one slot per cycle, first exact size match wins
      fbrc_pkg::ST_FIND_CHK: begin
        add_opnd = req_size;
        if (row_match) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_kind  = fbrc_pkg::K_HIT;
            emit_ptr   = rd_row.ptr;
            emit_bytes = req_size;
            emit_total = add_sum;
            emit_last  = 1'b1;
            held_we    = 1'b1;
            valid_we   = 1'b1;
            state_next = fbrc_pkg::ST_IDLE;
          end
        end else if (idx_inc < act_cnt) begin
          idx_next = idx_inc[IDX_W-1:0];
        end else begin
          state_next = fbrc_pkg::ST_MISS;
        end
      end

      fbrc_pkg::ST_MISS: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = fbrc_pkg::K_MISS;
          emit_last  = 1'b1;
          state_next = fbrc_pkg::ST_IDLE;
        end
      end

      // release every occupied slot over the whole table
      fbrc_pkg::ST_CLR_CHK: begin
        if (!valid[idx] || out_free) begin
          if (valid[idx]) begin
            emit       = 1'b1;
            emit_kind  = fbrc_pkg::K_RELEASE;
            emit_ptr   = rd_row.ptr;
            emit_bytes = rd_row.size;
            emit_total = add_sum;
            held_we    = 1'b1;
            valid_we   = 1'b1;
          end
          if (idx == LAST_IDX) begin
            state_next = fbrc_pkg::ST_CLR_DONE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end

      fbrc_pkg::ST_CLR_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = fbrc_pkg::K_DONE;
          emit_total = '0;
          emit_last  = 1'b1;
          held_clr   = 1'b1;
          state_next = fbrc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = fbrc_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbrc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx            <= '0;
      next_slot      <= '0;
      held_total     <= '0;
      valid          <= '0;
      entries_in_use <= CFG_RST;
      out_valid      <= 1'b0;
    end else begin
      idx <= idx_next;
      if (ns_we) begin
        next_slot <= next_slot_next;
      end
      if (held_clr) begin
        held_total <= '0;
      end else if (held_we) begin
        held_total <= add_sum;
      end
      if (valid_we) begin
        valid[idx] <= valid_val;
      end
      if (cfg_valid && cfg_ready) begin
        entries_in_use <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_func <= fbrc_pkg::func_t'(s_tuser);
      req_ptr  <= s_tdata[0 +: fbrc_pkg::PTR_W];
      req_size <= s_tdata[fbrc_pkg::PTR_W +: fbrc_pkg::SIZE_W];
    end
    if (emit) begin
      out_kind  <= emit_kind;
      out_ptr   <= emit_ptr;
      out_bytes <= emit_bytes;
      out_total <= emit_total;
      out_last  <= emit_last;
    end
  end

  // Slot table: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= '{ptr: req_ptr, size: req_size};
    end
    rd_row <= mem[idx_next];
  end

  // A release never ends an item's results
  a_release_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == fbrc_pkg::K_RELEASE) |-> !m_tlast)
    else $error("release result marked last");

  // A clear leaves every slot empty
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == fbrc_pkg::ST_CLR_DONE && out_free) |=> (valid == '0))
    else $error("slots still occupied after clear");

  // The round-robin slot stays inside the active range after an insert
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == fbrc_pkg::ST_INS_WR && out_free) |=>
      (CNT_W'(next_slot) < $past(act_cnt)))
    else $error("round-robin slot out of range");

  // Stored, miss and done results carry no block
  a_empty_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == fbrc_pkg::K_STORED || m_tuser == fbrc_pkg::K_MISS ||
                  m_tuser == fbrc_pkg::K_DONE))
      |-> (m_tdata[fbrc_pkg::PTR_W + fbrc_pkg::SIZE_W - 1:0] == '0))
    else $error("nonzero block fields on an empty result");

  // An insert request only reaches the write step through its own path
  a_insert_path: assert property (@(posedge clk) disable iff (rst)
    (state == fbrc_pkg::ST_INS_WR) |-> (req_func == fbrc_pkg::FN_INSERT))
    else $error("write step entered for a non-insert item");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS       = 16;
  localparam int TAIL_CYCLES = SLOTS + 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 32;

  // One request toward the cache; hold makes the sender wait for an empty scoreboard
  typedef struct {
    fbrc_pkg::func_t             func;
    logic [fbrc_pkg::PTR_W-1:0]  ptr;
    logic [fbrc_pkg::SIZE_W-1:0] size;
    bit                          hold;
  } block_req_t;

  typedef struct {
    fbrc_pkg::kind_t              kind;
    logic [fbrc_pkg::PTR_W-1:0]   ptr;
    logic [fbrc_pkg::SIZE_W-1:0]  bytes;
    logic [fbrc_pkg::TOTAL_W-1:0] total;
    logic                         last;
  } cache_result_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic [fbrc_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
  logic [fbrc_pkg::FUNC_W-1:0]     s_tuser   = '0;
  logic                            m_tready  = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [fbrc_pkg::CFG_W-1:0]      cfg_data  = '0;
  logic                            s_tready;
  logic                            m_tvalid;
  logic [fbrc_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [fbrc_pkg::KIND_W-1:0]     m_tuser;
  logic                            m_tlast;
  logic                            cfg_ready;

  free_block_recycle_cache_core #(.DEPTH(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Mirror of the cache table
  logic [fbrc_pkg::PTR_W-1:0]   mirror_ptr  [SLOTS];
  logic [fbrc_pkg::SIZE_W-1:0]  mirror_size [SLOTS];
  int unsigned                  rr_slot = 0;
  logic [fbrc_pkg::TOTAL_W-1:0] mirror_total = '0;
  logic [fbrc_pkg::CFG_W-1:0]   entries_cfg = 5'd16;

  block_req_t    pending_reqs[$];
  cache_result_t awaited_results[$];
  block_req_t    cur_req;
  logic [fbrc_pkg::SIZE_W-1:0] size_pool[4];

  int queued_cnt = 0, accepted_cnt = 0, errors = 0;
  int n_insert = 0, n_find = 0, n_clear = 0, n_nop = 0;
  int n_results = 0, n_hits = 0, n_misses = 0, n_releases = 0;
  int gap_left = 0, burst_left = 1, quiet_cycles = 0;
  logic [7:0] rdy_phase = '0;
  logic [1:0] rdy_mode  = '0;

  task automatic push_result(input fbrc_pkg::kind_t k,
                             input logic [fbrc_pkg::PTR_W-1:0] p,
                             input logic [fbrc_pkg::SIZE_W-1:0] b, input logic l);
    awaited_results.push_back('{k, p, b, mirror_total, l});
  endtask

  // Work out the results of one accepted request and update the mirror
  task automatic predict_recycle(input block_req_t r);
    int unsigned n, s, i;
    bit found;
    n = (entries_cfg == 0) ? 1 : (entries_cfg > SLOTS) ? SLOTS : entries_cfg;
    case (r.func)
      fbrc_pkg::FN_INSERT: begin
        // round-robin slot may be stale after the slot count was lowered
        s = (rr_slot < n) ? rr_slot : 0;
        if (mirror_size[s] != 0) begin
          mirror_total = mirror_total - mirror_size[s];
          push_result(fbrc_pkg::K_RELEASE, mirror_ptr[s], mirror_size[s], 1'b0);
        end
        mirror_ptr[s]  = r.ptr;
        mirror_size[s] = r.size;
        mirror_total   = mirror_total + r.size;
        rr_slot = (s + 1 < n) ? s + 1 : 0;
        push_result(fbrc_pkg::K_STORED, '0, '0, 1'b1);
      end
      fbrc_pkg::FN_FIND: begin
        // zero size never matches: it marks an empty slot
        found = 1'b0;
        for (i = 0; i < n && !found && r.size != 0; i++) begin
          if (mirror_size[i] == r.size) begin
            found = 1'b1;
            mirror_size[i] = '0;
            mirror_total   = mirror_total - r.size;
            push_result(fbrc_pkg::K_HIT, mirror_ptr[i], r.size, 1'b1);
          end
        end
        if (!found) push_result(fbrc_pkg::K_MISS, '0, '0, 1'b1);
      end
      fbrc_pkg::FN_CLEAR: begin
        // all slots are flushed, including those beyond the count in use
        for (i = 0; i < SLOTS; i++) begin
          if (mirror_size[i] != 0) begin
            mirror_total = mirror_total - mirror_size[i];
            push_result(fbrc_pkg::K_RELEASE, mirror_ptr[i], mirror_size[i], 1'b0);
            mirror_size[i] = '0;
          end
        end
        mirror_total = '0;
        push_result(fbrc_pkg::K_DONE, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endtask

  // Sender: bursts of random length, random gaps in between
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left   = 0;
      burst_left = 1;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_recycle(cur_req);
        accepted_cnt++;
        case (cur_req.func)
          fbrc_pkg::FN_INSERT: n_insert++;
          fbrc_pkg::FN_FIND:   n_find++;
          fbrc_pkg::FN_CLEAR:  n_clear++;
          default:             n_nop++;
        endcase
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].hold && awaited_results.size() != 0)) begin
          cur_req = pending_reqs.pop_front();
          s_tuser  <= cur_req.func;
          s_tdata  <= {cur_req.size, cur_req.ptr};
          s_tvalid <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches whenever the low six bits of the phase counter wrap to zero
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rdy_phase <= rdy_phase + 8'd1;
      if (rdy_phase[5:0] == 6'd0) rdy_mode <= 2'($urandom_range(0, 3));
      case (rdy_mode)
        2'd0:    m_tready <= 1'b1;
        2'd1:    m_tready <= 1'($urandom_range(0, 1));
        2'd2:    m_tready <= (rdy_phase[1:0] == 2'd3);
        default: m_tready <= (rdy_phase[3:0] < 4'd5);
      endcase
    end
  end

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      case (m_tuser)
        fbrc_pkg::K_HIT:     n_hits++;
        fbrc_pkg::K_MISS:    n_misses++;
        fbrc_pkg::K_RELEASE: n_releases++;
        default: ;
      endcase
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, kind %0d pointer %h", $time, m_tuser,
                 m_tdata[63:0]);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        report_field("kind", 64'(want.kind), 64'(m_tuser));
        report_field("out_pointer", want.ptr, m_tdata[63:0]);
        report_field("out_bytes", 64'(want.bytes), 64'(m_tdata[111:64]));
        report_field("total_held", 64'(want.total), 64'(m_tdata[163:112]));
        report_field("last", 64'(want.last), 64'(m_tlast));
      end
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_req(input fbrc_pkg::func_t f, input logic [fbrc_pkg::PTR_W-1:0] p,
                         input logic [fbrc_pkg::SIZE_W-1:0] sz, input bit hold = 1'b0);
    pending_reqs.push_back('{f, p, sz, hold});
    queued_cnt++;
  endtask

  // Wait until every request is taken and answered, then let the scan settle
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_entries(input logic [fbrc_pkg::CFG_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    entries_cfg = v;
  endtask

  function automatic logic [fbrc_pkg::SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2, 3:    return fbrc_pkg::SIZE_W'({$urandom, $urandom});
      default: return size_pool[$urandom_range(0, 3)];
    endcase
  endfunction

  function automatic logic [fbrc_pkg::PTR_W-1:0] pick_ptr();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly inserts and finds over a small size set so finds hit and slots evict
  task automatic gen_random(input int count);
    int made, pick;
    bit hold;
    size_pool[0] = fbrc_pkg::SIZE_W'($urandom_range(1, 20));
    size_pool[1] = fbrc_pkg::SIZE_W'($urandom_range(1, 20));
    size_pool[2] = fbrc_pkg::SIZE_W'($urandom_range(1, 4));
    size_pool[3] = fbrc_pkg::SIZE_W'({$urandom, $urandom});
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      hold = (made == count / 2) || ($urandom_range(0, 24) == 0);
      if (pick < 45)      add_req(fbrc_pkg::FN_INSERT, pick_ptr(), pick_size(), hold);
      else if (pick < 85) add_req(fbrc_pkg::FN_FIND, pick_ptr(), pick_size(), hold);
      else if (pick < 94) add_req(fbrc_pkg::FN_CLEAR, pick_ptr(), pick_size(), hold);
      else                add_req(fbrc_pkg::FN_NOP, pick_ptr(), pick_size(), hold);
      if (pick < 94) made++;
    end
  endtask

  initial begin
    logic [fbrc_pkg::CFG_W-1:0] sweep[6];
    for (int i = 0; i < SLOTS; i++) begin
      mirror_ptr[i]  = '0;
      mirror_size[i] = '0;
    end
    sweep = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd16, fbrc_pkg::CFG_W'($urandom_range(2, 15))};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, full table: misses on empty and zero size, extremes, duplicates
    add_req(fbrc_pkg::FN_FIND, '0, 48'd5);
    add_req(fbrc_pkg::FN_FIND, '1, '0);
    add_req(fbrc_pkg::FN_INSERT, '1, '1);
    add_req(fbrc_pkg::FN_INSERT, '0, 48'd1);
    add_req(fbrc_pkg::FN_INSERT, 64'h123, '0);
    add_req(fbrc_pkg::FN_INSERT, 64'hA5A5_A5A5_5A5A_5A5A, 48'd7);
    add_req(fbrc_pkg::FN_FIND, '0, '1);
    add_req(fbrc_pkg::FN_FIND, '0, '0);
    add_req(fbrc_pkg::FN_NOP, '1, '1);
    add_req(fbrc_pkg::FN_INSERT, 64'h0F0F_0000_F0F0_FFFF, 48'd7);
    add_req(fbrc_pkg::FN_FIND, '0, 48'd7);
    wait_idle();

    // Directed, two slots: stale round-robin slot, evictions, slot beyond count
    write_entries(5'd2);
    add_req(fbrc_pkg::FN_INSERT, 64'h8000_0000_0000_0001, 48'd9);
    add_req(fbrc_pkg::FN_FIND, '0, 48'd7);
    add_req(fbrc_pkg::FN_INSERT, '1, 48'd2);
    add_req(fbrc_pkg::FN_INSERT, 64'h55, '0);
    add_req(fbrc_pkg::FN_INSERT, 64'hDEAD_BEEF_0000_0001, 48'd3);
    add_req(fbrc_pkg::FN_CLEAR, '0, '0);
    wait_idle();

    // Random phases over a sweep of slot counts, extremes included
    foreach (sweep[k]) begin
      write_entries(sweep[k]);
      gen_random(PHASE_ITEMS);
      wait_idle();
    end

    $display("Covered %0d inserts, %0d finds, %0d clears, %0d ignored ops, %0d slot counts",
             n_insert, n_find, n_clear, n_nop, $size(sweep) + 2);
    $display("Checked %0d results: %0d hits, %0d misses, %0d releases; %0d errors",
             n_results, n_hits, n_misses, n_releases, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
